// ===== rtl/core/hlsfr_pkg.sv =====
// Package for the header/length/sum frame receiver.
// Opcode and status codes, header bytes, register defaults and sizes.
// No dependencies.
`default_nettype none

package hlsfr_pkg;

   localparam int BUFFER_DEPTH_DEF = 2048;

   localparam int OPCODE_W   = 3;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 11;
   localparam int TIMER_W    = 16;
   localparam int COUNTER_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0] HDR_FIRST     = 8'hA5;
   localparam logic [7:0] HDR_SECOND    = 8'h5A;
   localparam logic [7:0] MIN_FRAME_LEN = 8'd10;

   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd200;
   localparam logic [COUNT_W-1:0] LIMIT_RESET   = 11'd1544;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_LIMIT   = 1'b1
   } csr_index_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_BYTE     = 3'd0,
      OP_MS_TICK  = 3'd1,
      OP_TMR_TICK = 3'd2,
      OP_OVERRUN  = 3'd3,
      OP_READ     = 3'd4,
      OP_CLEAR    = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE     = 3'd0,
      ST_GOOD     = 3'd1,
      ST_CHECKSUM = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_TIMEOUT  = 3'd4,
      ST_OVERRUN  = 3'd5,
      ST_READ     = 3'd6
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/header_length_sum_frame_receiver.sv =====
// Header/length/sum frame receiver: header hunt, frame store, checksum, timer.
// Depends on hlsfr_pkg. Frame bytes live in a synchronous single-port store.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | opcode, data_byte, read_index
//   rsp_     | out       | rsp_valid/rsp_stall  | status, read_data, counts, totals
//   csr_     | in        | csr_we               | csr_index, csr_wdata
//
// One transfer per cycle while req_stall is low: each request yields one response on the next cycle.
// A buffer read is a registered store read, issued at the request transfer.
// req_stall is high only while a response waits and rsp_stall is high.
// Synchronous reset clears all counters and flags; the store is not cleared.
`default_nettype none

module header_length_sum_frame_receiver #(
   parameter int BUFFER_DEPTH = hlsfr_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [hlsfr_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic [hlsfr_pkg::COUNT_W-1:0]       req_read_index,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [hlsfr_pkg::STATUS_W-1:0]           rsp_status,
   output logic [7:0]                               rsp_read_data,
   output logic                                     rsp_frame_ready,
   output logic [hlsfr_pkg::COUNT_W-1:0]            rsp_byte_count,
   output logic [hlsfr_pkg::COUNTER_W-1:0]          rsp_overflow_total,
   output logic [hlsfr_pkg::COUNTER_W-1:0]          rsp_checksum_error_total,
   output logic [hlsfr_pkg::COUNTER_W-1:0]          rsp_overrun_total,
   input  wire logic                                csr_we,
   input  wire logic [hlsfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hlsfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int PW = ((AW > hlsfr_pkg::COUNT_W) ? AW : hlsfr_pkg::COUNT_W) + 1;
   localparam int CW = hlsfr_pkg::COUNT_W;
   localparam int TW = hlsfr_pkg::TIMER_W;
   localparam int NW = hlsfr_pkg::COUNTER_W;

   logic [7:0] mem [BUFFER_DEPTH];

   logic [TW-1:0] timeout_ff;
   logic [CW-1:0] limit_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    len_ff;
   logic [TW-1:0] timer_ff, timer_in;
   logic          ready_ff, ready_in;
   logic [NW-1:0] ovf_ff, ovf_in;
   logic [NW-1:0] mis_ff, mis_in;
   logic [NW-1:0] orun_ff, orun_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hlsfr_pkg::status_type status_ff, status_in;
   logic          rd_sel_ff;
   logic [7:0]    rd_q_ff;

   logic          acc;
   hlsfr_pkg::opcode_type op;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    flen;
   logic [CW-1:0] fill_inc;
   logic [TW-1:0] timer_dec;
   logic [PW-1:0] pos_w;
   logic [PW-1:0] rd_pos_w;
   logic          pos_ok;
   logic          rd_ok;
   logic          rd_en;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign acc       = req_valid & ~req_stall;
   assign op        = hlsfr_pkg::opcode_type'(req_opcode);

   assign pos_w    = PW'(fill_ff);
   assign pos_ok   = pos_w < PW'(BUFFER_DEPTH);
   assign rd_pos_w = PW'(req_read_index);
   assign rd_ok    = rd_pos_w < PW'(BUFFER_DEPTH);
   assign rd_en    = acc && (op == hlsfr_pkg::OP_READ) && rd_ok;

   assign fill_inc  = fill_ff + CW'(1);
   assign timer_dec = timer_ff - TW'(1);
   // length byte: written this transfer when at position 2, else the stored copy
   assign flen      = (fill_ff == CW'(2)) ? req_data_byte : len_ff;

   always_comb begin
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      timer_in  = timer_ff;
      ready_in  = ready_ff;
      ovf_in    = ovf_ff;
      mis_in    = mis_ff;
      orun_in   = orun_ff;
      status_in = hlsfr_pkg::ST_NONE;
      wr_en     = 1'b0;
      wr_addr   = pos_w[AW-1:0];
      case (op)
         hlsfr_pkg::OP_BYTE: begin
            if (fill_ff >= limit_ff) begin
               fill_in   = '0;
               ovf_in    = ovf_ff + NW'(1);
               status_in = hlsfr_pkg::ST_OVERFLOW;
            end else begin
               timer_in = timeout_ff;
               if (fill_ff == CW'(0)) begin
                  if (req_data_byte == hlsfr_pkg::HDR_FIRST) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     sum_in  = req_data_byte;
                     fill_in = CW'(1);
                  end
               end else if (fill_ff == CW'(1)) begin
                  if (req_data_byte == hlsfr_pkg::HDR_SECOND) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(1);
                     sum_in  = sum_ff + req_data_byte;
                     fill_in = CW'(2);
                  end else if (req_data_byte == hlsfr_pkg::HDR_FIRST) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     sum_in  = req_data_byte;
                     fill_in = CW'(1);
                  end else begin
                     fill_in = '0;
                  end
               end else begin
                  wr_en = pos_ok;
                  if ((flen > hlsfr_pkg::MIN_FRAME_LEN) && (fill_inc >= CW'(flen))) begin
                     if (sum_ff == req_data_byte) begin
                        ready_in  = 1'b1;
                        status_in = hlsfr_pkg::ST_GOOD;
                     end else begin
                        mis_in    = mis_ff + NW'(1);
                        status_in = hlsfr_pkg::ST_CHECKSUM;
                     end
                     fill_in = '0;
                     sum_in  = '0;
                  end else begin
                     fill_in = fill_inc;
                     sum_in  = sum_ff + req_data_byte;
                  end
               end
            end
         end
         hlsfr_pkg::OP_MS_TICK: begin
            if (timer_ff != '0) begin
               timer_in = timer_dec;
               if (timer_dec == '0) begin
                  ready_in  = 1'b1;
                  status_in = hlsfr_pkg::ST_TIMEOUT;
               end
            end
         end
         hlsfr_pkg::OP_TMR_TICK: begin
            if (timer_ff != '0) begin
               timer_in = timer_dec;
               if ((timer_dec == '0) && (fill_ff != '0)) begin
                  ready_in  = 1'b1;
                  status_in = hlsfr_pkg::ST_TIMEOUT;
               end
            end
         end
         hlsfr_pkg::OP_OVERRUN: begin
            orun_in   = orun_ff + NW'(1);
            status_in = hlsfr_pkg::ST_OVERRUN;
         end
         hlsfr_pkg::OP_READ: begin
            status_in = hlsfr_pkg::ST_READ;
         end
         hlsfr_pkg::OP_CLEAR: begin
            ready_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (acc) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= hlsfr_pkg::TIMEOUT_RESET;
         limit_ff     <= hlsfr_pkg::LIMIT_RESET;
         fill_ff      <= '0;
         sum_ff       <= '0;
         timer_ff     <= '0;
         ready_ff     <= 1'b0;
         ovf_ff       <= '0;
         mis_ff       <= '0;
         orun_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= hlsfr_pkg::ST_NONE;
         rd_sel_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (hlsfr_pkg::csr_index_type'(csr_index))
               hlsfr_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata[TW-1:0];
               hlsfr_pkg::CSR_LIMIT:   limit_ff   <= csr_wdata[CW-1:0];
               default: begin
               end
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         if (acc) begin
            fill_ff   <= fill_in;
            sum_ff    <= sum_in;
            timer_ff  <= timer_in;
            ready_ff  <= ready_in;
            ovf_ff    <= ovf_in;
            mis_ff    <= mis_in;
            orun_ff   <= orun_in;
            status_ff <= status_in;
            rd_sel_ff <= rd_en;
         end
      end
   end

   // length copy of store entry 2
   always_ff @(posedge clock) begin
      if (acc && wr_en && (pos_w == PW'(2)) && (fill_ff == CW'(2))) begin
         len_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && wr_en) begin
         mem[wr_addr] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= mem[rd_pos_w[AW-1:0]];
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_ff;
   assign rsp_read_data            = rd_sel_ff ? rd_q_ff : 8'd0;
   assign rsp_frame_ready          = ready_ff;
   assign rsp_byte_count           = fill_ff;
   assign rsp_overflow_total       = ovf_ff;
   assign rsp_checksum_error_total = mis_ff;
   assign rsp_overrun_total        = orun_ff;

`ifndef SYNTHESIS
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      acc |=> rsp_valid_ff)
      else $error("request transfer without response");

   a_ovf_count: assert property (@(posedge clock) disable iff (reset)
      acc |=> ((ovf_ff != $past(ovf_ff)) == (status_ff == hlsfr_pkg::ST_OVERFLOW)))
      else $error("overflow total out of step with status");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_read_data != 8'd0)) |-> (status_ff == hlsfr_pkg::ST_READ))
      else $error("read data on a non-read response");

   a_good_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == hlsfr_pkg::ST_GOOD)) |-> (ready_ff && (fill_ff == '0)))
      else $error("good frame without ready flag");
`endif

endmodule

`default_nettype wire
